// File: rtl/gulcd_pkg.sv
`default_nettype none
package gulcd_pkg;

  localparam logic [7:0] BYTE_C2     = 8'hC2;
  localparam logic [7:0] BYTE_B0     = 8'hB0;
  localparam logic [7:0] BYTE_CE     = 8'hCE;
  localparam logic [7:0] BYTE_CF     = 8'hCF;
  localparam logic [7:0] CODE_THETA  = 8'd242;
  localparam logic [7:0] CODE_SIGMA  = 8'd246;
  localparam logic [7:0] CODE_QMARK  = 8'h3F;
  localparam logic [7:0] DEGREE_RST  = 8'd223;

  localparam logic [2:0] ADDR_DEGREE = 3'd0;

  typedef enum logic [3:0] {
    LEAD_NONE = 4'b0001,
    LEAD_C2   = 4'b0010,
    LEAD_CE   = 4'b0100,
    LEAD_CF   = 4'b1000
  } lead_t;

  typedef struct packed {
    logic [7:0] code;
    logic       run_last;
    logic       text_last;
  } res_t;

  // decode of one word: up to two codes, plus the lead left pending
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
    lead_t      next_lead;
  } dec_t;

  function automatic logic [7:0] map_ce(input logic [7:0] b);
    logic [7:0] c;
    case (b)
      8'h91:   c = 8'h41;  // A
      8'h92:   c = 8'h42;  // B
      8'h93:   c = 8'd0;
      8'h94:   c = 8'd1;
      8'h95:   c = 8'h45;  // E
      8'h96:   c = 8'h5A;  // Z
      8'h97:   c = 8'h48;  // H
      8'h98:   c = CODE_THETA;
      8'h99:   c = 8'h49;  // I
      8'h9A:   c = 8'h4B;  // K
      8'h9B:   c = 8'd2;
      8'h9C:   c = 8'h4D;  // M
      8'h9D:   c = 8'h4E;  // N
      8'h9E:   c = 8'd3;
      8'h9F:   c = 8'h4F;  // O
      8'hA0:   c = 8'd4;
      8'hA1:   c = 8'h50;  // P
      8'hA3:   c = CODE_SIGMA;
      8'hA4:   c = 8'h54;  // T
      8'hA5:   c = 8'h59;  // Y
      8'hA6:   c = 8'd5;
      8'hA7:   c = 8'h58;  // X
      8'hA8:   c = 8'd6;
      8'hA9:   c = 8'd7;
      default: c = CODE_QMARK;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] map_cf(input logic [7:0] b);
    logic [7:0] c;
    case (b)
      8'h80:   c = 8'h50;  // P
      8'h81:   c = 8'h52;  // R
      8'h82:   c = CODE_SIGMA;
      8'h83:   c = CODE_SIGMA;
      default: c = CODE_QMARK;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/gulcd_dec.sv
`default_nettype none
module gulcd_dec
  import gulcd_pkg::*;
(
  input  wire logic [7:0] text_byte,
  input  wire logic       text_end,
  input  wire lead_t      lead,
  input  wire logic [7:0] degree_code,
  output dec_t            dec
);

  logic       is_lead;
  logic [7:0] fresh_code;
  logic       fresh_emit;
  lead_t      fresh_lead;
  logic [7:0] code0;
  logic [7:0] code1;
  logic [1:0] n;
  lead_t      nl;

  // handling of a word with nothing pending
  always_comb begin
    is_lead    = (text_byte == BYTE_C2) || (text_byte == BYTE_CE) || (text_byte == BYTE_CF);
    fresh_code = text_byte;
    fresh_emit = 1'b1;
    fresh_lead = LEAD_NONE;
    if (is_lead) begin
      if (text_end) begin
        fresh_code = (text_byte == BYTE_C2) ? BYTE_C2 : CODE_QMARK;
      end else begin
        fresh_emit = 1'b0;
        if (text_byte == BYTE_C2) begin
          fresh_lead = LEAD_C2;
        end else if (text_byte == BYTE_CE) begin
          fresh_lead = LEAD_CE;
        end else begin
          fresh_lead = LEAD_CF;
        end
      end
    end
  end

  always_comb begin
    code0 = fresh_code;
    code1 = fresh_code;
    n     = 2'd1;
    nl    = LEAD_NONE;
    case (lead)
      LEAD_C2: begin
        if (text_byte == BYTE_B0) begin
          code0 = degree_code;
        end else begin
          code0 = BYTE_C2;
          n     = fresh_emit ? 2'd2 : 2'd1;
          nl    = fresh_lead;
        end
      end
      LEAD_CE: code0 = map_ce(text_byte);
      LEAD_CF: code0 = map_cf(text_byte);
      default: begin
        n  = fresh_emit ? 2'd1 : 2'd0;
        nl = fresh_lead;
      end
    endcase
    if (text_end) begin
      nl = LEAD_NONE;
    end
  end

  always_comb begin
    dec.count            = n;
    dec.first.code       = code0;
    dec.first.run_last   = (n == 2'd1);
    dec.first.text_last  = (n == 2'd1) && text_end;
    dec.second.code      = code1;
    dec.second.run_last  = 1'b1;
    dec.second.text_last = text_end;
    dec.next_lead        = nl;
  end

endmodule
`default_nettype wire

// File: rtl/gulcd_obuf.sv
`default_nettype none
module gulcd_obuf
  import gulcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_en,
  input  wire dec_t       dec,
  output logic            room,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_lcd_code,
  output logic            out_run_last,
  output logic            out_text_last
);

  localparam int DEPTH = 4;

  res_t       q_r [DEPTH];
  logic [1:0] wptr_r, wptr_nxt;
  logic [1:0] rptr_r, rptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] n_wr;
  logic       pop;
  logic [1:0] wptr1;

  assign room      = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && out_ready;
  assign n_wr      = wr_en ? dec.count : 2'd0;
  assign wptr1     = wptr_r + 2'd1;

  assign out_lcd_code  = q_r[rptr_r].code;
  assign out_run_last  = q_r[rptr_r].run_last;
  assign out_text_last = q_r[rptr_r].text_last;

  always_comb begin
    wptr_nxt = wptr_r + n_wr;
    rptr_nxt = rptr_r + {1'b0, pop};
    cnt_nxt  = cnt_r + {1'b0, n_wr} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      q_r[wptr_r] <= dec.first;
    end
    if (n_wr == 2'd2) begin
      q_r[wptr1] <= dec.second;
    end
  end

endmodule
`default_nettype wire

// File: rtl/greek_utf8_to_lcd_code.sv
`default_nettype none
// Greek UTF-8 text to character-LCD codes.
// Input channel (in_valid/in_ready): one text word per transfer, in_text_end
// marks the last word of a text. Output channel (out_valid/out_ready): one
// LCD code per transfer; out_run_last closes the codes caused by one input
// word, out_text_last marks the final code of the text.
// Input words go into an input register; decode runs from that register and
// writes zero, one or two codes into a four-entry output queue. An input word
// passes through the input register and then a queue entry on its way out.
// Throughput is one word per cycle while the queue drains one code per cycle;
// the queue's single read port limits output to one code per cycle, so a word
// that yields two codes needs two output transfers downstream.
// in_ready drops when the input register is full and the queue has fewer than
// two free entries; a stalled receiver thus backs up into the input after a
// few words. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the queue and input register, drops
// any pending lead byte and sets the degree code to 223.
// APB register at byte 0: degree_code (bits 7:0). Write only while idle.
module greek_utf8_to_lcd_code
  import gulcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_text_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_lcd_code,
  output logic             out_run_last,
  output logic             out_text_last,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [7:0] degree_r;
  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  lead_t      lead_r;
  dec_t       dec;
  logic       room;
  logic       s1_go;
  logic       in_take;
  logic       cfg_wr;
  logic       cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == ADDR_DEGREE[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? {24'd0, degree_r} : 32'd0;

  assign s1_go    = s1_v_r && room;
  assign in_ready = !s1_v_r || room;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= DEGREE_RST;
      s1_v_r   <= 1'b0;
      lead_r   <= LEAD_NONE;
    end else begin
      if (cfg_wr) begin
        degree_r <= cfg_pwdata[7:0];
      end
      if (in_take) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        lead_r <= dec.next_lead;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_text_byte;
      s1_end_r  <= in_text_end;
    end
  end

  gulcd_dec u_dec (
    .text_byte   (s1_byte_r),
    .text_end    (s1_end_r),
    .lead        (lead_r),
    .degree_code (degree_r),
    .dec         (dec)
  );

  gulcd_obuf u_obuf (
    .clk           (clk),
    .rst_n         (rst_n),
    .wr_en         (s1_go),
    .dec           (dec),
    .room          (room),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_lcd_code  (out_lcd_code),
    .out_run_last  (out_run_last),
    .out_text_last (out_text_last)
  );

endmodule
`default_nettype wire
